>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> rtl/core/drpbc_pkg.sv
package drpbc_pkg;

    localparam logic [7:0] RUN_MIN      = 8'd13;
    localparam logic [7:0] RUN_MAX      = 8'd255;
    // long run head, sent LSB first: 1, 1, then tag 4 in three bits
    localparam logic [4:0] RUN_HEAD     = 5'b10011;
    localparam logic [3:0] RUN_HEAD_LEN = 4'd13;

    localparam logic [3:0] CB_MIN   = 4'd4;
    localparam logic [3:0] CB_MAX   = 4'd8;
    localparam logic [3:0] CB_RESET = 4'd8;
    localparam logic       RE_RESET = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_COLOR_BITS = 1'b0;
    localparam logic REG_RUN_ENABLE = 1'b1;

    typedef struct packed {
        logic [15:0] length;
        logic        stream_end;
        logic        item_last;
        logic        byte_valid;
        logic [7:0]  data;
    } t_beat;

endpackage

>>> rtl/core/delta_run_pixel_bit_coder.sv
// Bit-serial coder: one coded bit per cycle through a byte shift register, while the
// output register can take each completed byte. A pixel is accepted only when idle;
// its run bits, then its code bits, then on the last pixel the padding of the last
// partial byte are shifted out, then the item is closed; output stalls hold both.
// A new pixel is not taken until the previous one has been closed.
// Reset (i_rst_n low, synchronous): stripe state cleared, color_bits 8, run_enable 1.
`include "assert_macros.svh"

module delta_run_pixel_bit_coder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tlast,   // last_pixel
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] stream_length
    output logic        m_tlast,   // item_last
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] stream_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drpbc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_cb;
    logic        r_re;
    logic [7:0]  r_color;
    logic        r_seen;
    logic [7:0]  r_cnt;
    logic [7:0]  r_byte;
    logic [2:0]  r_fill;
    logic [15:0] r_total;
    logic        r_last;
    logic        r_any;
    logic [12:0] r_run_sh;
    logic [3:0]  r_run_len;
    logic [9:0]  r_code_sh;
    logic [3:0]  r_code_len;
    logic [7:0]  r_hold;
    logic        r_hold_v;
    t_beat       r_out;
    logic        r_ov;

    logic        cfg_wr;
    logic        s_fire;
    logic        out_free;
    logic        out_load;
    logic        eq;
    logic [7:0]  newcnt;
    logic        send_now;
    logic [7:0]  run_cnt;
    logic [8:0]  d9;
    logic        short_delta;
    logic [3:0]  nb;
    logic        have_bit;
    logic        bit_val;
    logic        completes;
    logic        step;
    logic [7:0]  byte_next;
    logic [15:0] total_inc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (r_state == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !r_ov || m_tready;

    always_comb begin
        case (paddr[2])
            REG_COLOR_BITS: prdata = {28'd0, r_cb};
            REG_RUN_ENABLE: prdata = {31'd0, r_re};
            default:        prdata = 32'd0;
        endcase
    end

    // pixel classification at accept
    assign eq          = r_seen && (s_tdata == r_color);
    assign newcnt      = r_cnt + 8'd1;
    assign send_now    = !r_re || (newcnt == RUN_MAX) || s_tlast;
    assign run_cnt     = !r_seen ? 8'd0 : (eq ? (send_now ? newcnt : 8'd0) : r_cnt);
    assign d9          = {1'b0, s_tdata} - {1'b0, r_color};
    assign short_delta = (!d9[8] && (d9[7:0] <= 8'd3)) || (d9[8:2] == 7'h7F);
    assign nb          = (r_cb > CB_MAX) ? CB_MAX : ((r_cb < CB_MIN) ? CB_MIN : r_cb);

    // bit source: run, then code, then zero padding of the last partial byte
    assign have_bit  = (r_run_len != 4'd0) || (r_code_len != 4'd0)
                    || (r_last && (r_fill != 3'd0));
    assign bit_val   = (r_run_len != 4'd0) ? r_run_sh[0]
                    : ((r_code_len != 4'd0) ? r_code_sh[0] : 1'b0);
    assign byte_next = {bit_val, r_byte[7:1]};
    assign completes = have_bit && (r_fill == 3'd7);
    assign step      = (r_state == ST_SHIFT) && have_bit
                    && !(completes && r_hold_v && !out_free);
    assign total_inc = (r_total == 16'hFFFF) ? r_total : r_total + 16'd1;

    // a new beat goes into the output register this cycle
    assign out_load  = (step && completes && r_hold_v)
                    || ((r_state == ST_DONE) && (n_state == ST_IDLE) && (r_hold_v || r_last));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_fire) n_state = ST_SHIFT;
            ST_SHIFT: if (!have_bit) n_state = ST_DONE;
            ST_DONE:  if (out_free || (!r_hold_v && !r_last)) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cb       <= CB_RESET;
            r_re       <= RE_RESET;
            r_color    <= 8'd0;
            r_seen     <= 1'b0;
            r_cnt      <= 8'd0;
            r_fill     <= 3'd0;
            r_total    <= 16'd0;
            r_last     <= 1'b0;
            r_any      <= 1'b0;
            r_run_len  <= 4'd0;
            r_code_len <= 4'd0;
            r_hold_v   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                case (paddr[2])
                    REG_COLOR_BITS: r_cb <= pwdata[3:0];
                    REG_RUN_ENABLE: r_re <= pwdata[0];
                    default: ;
                endcase
            end

            if (m_tready && !out_load) r_ov <= 1'b0;

            if (s_fire) begin
                r_last <= s_tlast;
                r_any  <= 1'b0;
                if (run_cnt >= RUN_MIN) begin
                    r_run_sh  <= {run_cnt, RUN_HEAD};
                    r_run_len <= RUN_HEAD_LEN;
                end else begin
                    r_run_sh  <= 13'd0;
                    r_run_len <= run_cnt[3:0];
                end
                if (!r_seen) begin
                    r_seen     <= 1'b1;
                    r_color    <= s_tdata;
                    r_code_sh  <= {2'b00, s_tdata};
                    r_code_len <= 4'd8;
                end else if (eq) begin
                    r_cnt      <= send_now ? 8'd0 : newcnt;
                    r_code_len <= 4'd0;
                end else begin
                    r_cnt   <= 8'd0;
                    r_color <= s_tdata;
                    if (short_delta) begin
                        r_code_sh  <= {5'd0, ~d9[2], d9[1:0], 2'b11};
                        r_code_len <= 4'd5;
                    end else begin
                        r_code_sh  <= {s_tdata, 2'b01};
                        r_code_len <= 4'd2 + nb;
                    end
                end
            end

            if (step) begin
                r_byte <= byte_next;
                r_fill <= r_fill + 3'd1;
                if (r_run_len != 4'd0) begin
                    r_run_sh  <= {1'b0, r_run_sh[12:1]};
                    r_run_len <= r_run_len - 4'd1;
                end else if (r_code_len != 4'd0) begin
                    r_code_sh  <= {1'b0, r_code_sh[9:1]};
                    r_code_len <= r_code_len - 4'd1;
                end
                if (completes) begin
                    r_hold   <= byte_next;
                    r_hold_v <= 1'b1;
                    r_any    <= 1'b1;
                    // earlier byte of this item leaves now, not the item's last
                    if (r_hold_v) begin
                        r_ov             <= 1'b1;
                        r_out.data       <= r_hold;
                        r_out.byte_valid <= 1'b1;
                        r_out.item_last  <= 1'b0;
                        r_out.stream_end <= 1'b0;
                        r_out.length     <= total_inc;
                        r_total          <= total_inc;
                    end
                end
            end

            if ((r_state == ST_DONE) && (n_state == ST_IDLE)) begin
                if (r_hold_v) begin
                    r_ov             <= 1'b1;
                    r_out.data       <= r_hold;
                    r_out.byte_valid <= 1'b1;
                    r_out.item_last  <= 1'b1;
                    r_out.stream_end <= r_last;
                    r_out.length     <= total_inc;
                    if (!r_last) r_total <= total_inc;
                    r_hold_v         <= 1'b0;
                end else if (r_last) begin
                    // empty end marker
                    r_ov             <= 1'b1;
                    r_out.data       <= 8'd0;
                    r_out.byte_valid <= 1'b0;
                    r_out.item_last  <= 1'b1;
                    r_out.stream_end <= 1'b1;
                    r_out.length     <= r_total;
                end
                if (r_last) begin
                    r_color <= 8'd0;
                    r_seen  <= 1'b0;
                    r_cnt   <= 8'd0;
                    r_fill  <= 3'd0;
                    r_total <= 16'd0;
                end
            end
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {r_out.length, r_out.data};
    assign m_tlast  = r_out.item_last;
    assign m_tuser  = {r_out.stream_end, r_out.byte_valid};

    `ASSERT_RST(a_end_is_item_last, i_clk, i_rst_n, (m_tvalid && m_tuser[1]) |-> m_tlast)
    `ASSERT_RST(a_marker_only_at_end, i_clk, i_rst_n,
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[1] && (m_tdata[7:0] == 8'd0)))
    `ASSERT_RST(a_count_below_max, i_clk, i_rst_n, (r_state == ST_IDLE) |-> (r_cnt != RUN_MAX))
    `ASSERT_NEXT(a_fire_leaves_idle, i_clk, i_rst_n, s_fire, (r_state == ST_SHIFT))
    `ASSERT_RST(a_any_with_hold, i_clk, i_rst_n, r_hold_v |-> r_any)

endmodule

>>> dv/tb_delta_run_pixel_bit_coder.sv
`timescale 1ns / 1ps

module tb_delta_run_pixel_bit_coder;
    import drpbc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned RANDOM_PIXELS = 150;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_COMB} t_rx_style;

    // Predicts the coded byte stream and holds the bytes still owed by the block.
    class t_coded_byte_board;
        logic [3:0]  color_bits;
        logic        run_enable;
        logic [7:0]  color;
        bit          seen;
        logic [7:0]  reps;
        logic [31:0] acc;
        int unsigned fill;
        logic [15:0] total;
        logic [7:0]  packed_bytes[$];
        t_beat       bytes_due[$];
        int          errors;

        function new();
            color_bits = CB_RESET;
            run_enable = RE_RESET;
            errors = 0;
            clear_stripe();
        endfunction

        function void clear_stripe();
            color = '0;
            seen = 1'b0;
            reps = '0;
            acc = '0;
            fill = 0;
            total = '0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_COLOR_BITS) begin
                color_bits = value[3:0];
            end else begin
                run_enable = value[0];
            end
        endfunction

        function void push_bits(logic [31:0] value, int unsigned n);
            logic [31:0] mask;
            mask = (n >= 8) ? 32'hFF : ((32'd1 << n) - 32'd1);
            acc |= (value & mask) << fill;
            fill += n;
            while (fill >= 8) begin
                if (packed_bytes.size() < 8) packed_bytes.push_back(acc[7:0]);
                acc >>= 8;
                fill -= 8;
            end
        endfunction

        function void flush_run();
            if (reps >= RUN_MIN) begin
                push_bits(32'(RUN_HEAD), 5);
                push_bits(32'(reps), 8);
            end else begin
                for (int k = 0; k < reps; k++) push_bits(0, 1);
            end
            reps = '0;
        endfunction

        function void note_pixel(logic [7:0] px, logic last);
            int unsigned nbits;
            int          delta;
            int          n_out;
            t_beat       b;
            logic [31:0] tail;
            nbits = 32'(color_bits);
            if (nbits > 32'(CB_MAX)) nbits = 32'(CB_MAX);
            if (nbits < 32'(CB_MIN)) nbits = 32'(CB_MIN);
            packed_bytes.delete();

            if (!seen) begin
                seen = 1'b1;
                color = px;
                push_bits(32'(px), 8);
            end else if (px == color) begin
                reps++;
                if (!run_enable || reps >= RUN_MAX) flush_run();
            end else begin
                delta = int'(px);
                delta = delta - int'(color);
                flush_run();
                push_bits(1, 1);
                if (delta >= -4 && delta <= 3) begin
                    push_bits(1, 1);
                    push_bits(delta + 4, 3);
                end else begin
                    push_bits(0, 1);
                    push_bits(32'(px), nbits);
                end
                color = px;
            end

            if (last) begin
                flush_run();
                if (fill > 0 && packed_bytes.size() < 8) begin
                    tail = acc & ((32'd1 << fill) - 32'd1);
                    packed_bytes.push_back(tail[7:0]);
                end
                acc = '0;
                fill = 0;
            end

            n_out = (packed_bytes.size() > 4) ? 4 : packed_bytes.size();
            for (int k = 0; k < n_out; k++) begin
                if (total != 16'hFFFF) total++;
                b.data = packed_bytes[k];
                b.byte_valid = 1'b1;
                b.item_last = (k == n_out - 1);
                b.stream_end = (k == n_out - 1) && last;
                b.length = total;
                bytes_due.push_back(b);
            end
            // end marker when the last pixel leaves nothing to send
            if (last && n_out == 0) begin
                b.data = '0;
                b.byte_valid = 1'b0;
                b.item_last = 1'b1;
                b.stream_end = 1'b1;
                b.length = total;
                bytes_due.push_back(b);
            end
            if (last) clear_stripe();
        endfunction

        function void compare_field(string label, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s expected %0h got %0h", label, want, got);
                errors++;
            end
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (bytes_due.size() == 0) begin
                $error("unexpected output beat, out_byte %0h", got.data);
                errors++;
                return;
            end
            want = bytes_due.pop_front();
            compare_field("out_byte", 16'(want.data), 16'(got.data));
            compare_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
            compare_field("item_last", 16'(want.item_last), 16'(got.item_last));
            compare_field("stream_end", 16'(want.stream_end), 16'(got.stream_end));
            compare_field("stream_length", want.length, got.length);
        endfunction

        function int unsigned outstanding();
            return bytes_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    t_coded_byte_board board;
    bit          calm = 1'b0;
    int          burst_left = 0;
    logic [7:0]  gen_color = '0;
    int          stripe_left = 0;
    int          run_left = 0;

    t_rx_style   rx_style = RX_OPEN;
    int          rx_tick = 0;
    int          rx_span = 50;

    delta_run_pixel_bit_coder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: stall style is picked anew at random
    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_tick >= rx_span) begin
            rx_tick = 0;
            rx_span = $urandom_range(20, 300);
            rx_style = t_rx_style'($urandom_range(0, 3));
        end
        if (calm) begin
            m_tready <= 1'b1;
        end else begin
            case (rx_style)
                RX_OPEN:  m_tready <= 1'b1;
                RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                RX_CHOKE: m_tready <= ($urandom_range(0, 3) == 0);
                default:  m_tready <= (rx_tick % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : watch
        t_beat got;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) board.note_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.data = m_tdata[7:0];
                got.length = m_tdata[23:8];
                got.item_last = m_tlast;
                got.byte_valid = m_tuser[0];
                got.stream_end = m_tuser[1];
                board.check_beat(got);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] px, input logic last);
        int gap;
        if (!calm && burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= px;
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic hold_until_empty();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // idle the block: nothing owed, and any item without output has finished
    task automatic settle();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] cbits, input logic runs);
        apb_write(REG_COLOR_BITS, ($urandom() & ~32'hF) | 32'(cbits));
        apb_write(REG_RUN_ENABLE, ($urandom() & ~32'h1) | 32'(runs));
    endtask

    task automatic next_pixel(output logic [7:0] px, output logic last);
        int pick;
        if (stripe_left == 0) begin
            stripe_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 40);
            run_left = 0;
        end
        if (run_left > 0) begin
            px = gen_color;
            run_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 14);
                px = gen_color;
                run_left--;
            end else if (pick < 60) begin
                px = gen_color + 8'($urandom_range(0, 7)) - 8'd4;
            end else if (pick < 90) begin
                px = 8'($urandom_range(0, 255));
            end else begin
                // just outside the short delta window
                px = gen_color + (($urandom_range(0, 1) == 1) ? 8'd4 : 8'hFB);
            end
        end
        gen_color = px;
        stripe_left--;
        last = (stripe_left == 0);
    endtask

    initial begin
        logic [7:0] px;
        logic       last;
        int         phase_left;
        int         sent;

        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: deltas at both ends, a literal, a threshold run, a short run
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h03, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFB, 1'b0);
        repeat (13) send_pixel(8'hFB, 1'b0);
        send_pixel(8'h7F, 1'b0);
        repeat (3) send_pixel(8'h7F, 1'b0);
        send_pixel(8'h80, 1'b1);
        // one-pixel stripe
        send_pixel(8'hA5, 1'b1);
        hold_until_empty();

        // full count, out-of-range color_bits above the top
        settle();
        set_config(4'd15, 1'b1);
        send_pixel(8'h55, 1'b0);
        repeat (260) send_pixel(8'h55, 1'b0);
        send_pixel(8'h50, 1'b0);
        send_pixel(8'h54, 1'b1);

        // long run collected with runs on, then sent after runs are switched off
        send_pixel(8'h10, 1'b0);
        repeat (15) send_pixel(8'h10, 1'b0);
        settle();
        set_config(4'd0, 1'b0);
        send_pixel(8'h10, 1'b0);
        send_pixel(8'h10, 1'b0);
        send_pixel(8'h11, 1'b0);
        send_pixel(8'h90, 1'b1);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            settle();
            case ($urandom_range(0, 6))
                0: set_config(4'd0, 1'($urandom_range(0, 1)));
                1: set_config(4'd3, 1'($urandom_range(0, 1)));
                2: set_config(4'd4, 1'($urandom_range(0, 1)));
                3: set_config(4'd8, 1'($urandom_range(0, 1)));
                4: set_config(4'd9, 1'($urandom_range(0, 1)));
                5: set_config(4'd15, 1'($urandom_range(0, 1)));
                default: set_config(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(30, 80);
            while (phase_left > 0 && sent < RANDOM_PIXELS) begin
                next_pixel(px, last);
                send_pixel(px, last);
                phase_left--;
                sent++;
                if ($urandom_range(0, 99) == 0) hold_until_empty();
            end
            calm = 1'b0;
        end
        if (stripe_left > 0) begin
            send_pixel(8'($urandom_range(0, 255)), 1'b1);
            stripe_left = 0;
        end

        settle();
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
